// ===== hw/rtl/lfre_pkg.sv =====
// Shared constants, codes and control types of the LCD frame-store refresh engine.
package lfre_pkg;

	localparam int PAGE_COUNT     = 8;
	localparam int CHIP_COLUMNS   = 64;
	localparam int ROW_BYTES      = 2 * CHIP_COLUMNS;
	localparam int STORE_BYTES    = PAGE_COUNT * ROW_BYTES;
	localparam int SLOTS_PER_PAGE = 4 + 2 * CHIP_COLUMNS;

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int SLOT_W = $clog2(SLOTS_PER_PAGE);
	localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

	localparam logic [7:0] BUSY_MASK   = 8'h90;
	localparam logic [7:0] CMD_PAGE    = 8'hB8;
	localparam logic [7:0] CMD_COLUMN0 = 8'h40;

	typedef enum logic [1:0] {
		FUNC_SET   = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_START = 2'd2,
		FUNC_STEP  = 2'd3
	} func_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic commit;
	} lfre_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic out_blocked;
	} lfre_status_t;

endpackage

// ===== hw/rtl/lfre_ctrl.sv =====
// Controller state machine of the LCD frame-store refresh engine.
module lfre_ctrl
	import lfre_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  lfre_status_t status,
	output lfre_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx     = state_q;
		cmd.clear_wr = 1'b0;
		cmd.load     = 1'b0;
		cmd.commit   = 1'b0;
		in_stall     = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The result waits here until the output register is free.
				if (!status.out_blocked) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== hw/rtl/lfre_datapath.sv =====
// Datapath of the LCD frame-store refresh engine: frame store, refresh position and result register.
module lfre_datapath
	import lfre_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  lfre_cmd_t    cmd,
	output lfre_status_t status,
	input  logic [1:0]   func,
	input  logic [6:0]   pixel_x,
	input  logic [5:0]   pixel_y,
	input  logic [7:0]   status_byte,
	output logic         out_valid,
	input  logic         out_stall,
	output logic         bus_valid,
	output logic         status_poll,
	output logic         chip_select,
	output logic         is_data,
	output logic [7:0]   bus_byte,
	output logic         frame_done,
	output logic         refresh_active
);

	logic [7:0] mem [STORE_BYTES];

	// Transaction held between acceptance and execution.
	logic [1:0]        func_q;
	logic [6:0]        x_q;
	logic [5:0]        y_q;
	logic [7:0]        stat_q;
	logic [7:0]        rd_data_q;

	logic              refr_q;
	logic [PAGE_W-1:0] page_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] clr_q;

	logic              out_valid_q;
	logic              bus_valid_q;
	logic              poll_q;
	logic              chip_q;
	logic              data_q;
	logic [7:0]        byte_q;
	logic              done_q;
	logic              active_q;

	logic [SLOT_W-1:0] slot_off;
	logic [ADDR_W-1:0] rd_addr;
	logic [2:0]        pix_page;
	logic              pix_in;
	logic [ADDR_W-1:0] pix_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;

	logic              r_bus_valid;
	logic              r_poll;
	logic              r_chip;
	logic              r_data;
	logic [7:0]        r_byte;
	logic              r_done;
	logic              refr_nx;
	logic [PAGE_W-1:0] page_nx;
	logic [SLOT_W-1:0] slot_nx;
	logic [SLOT_W-1:0] slot_inc;

	// Read address of the data slot at the current refresh position.
	assign slot_off = slot_q - SLOT_W'(4);
	assign rd_addr  = ADDR_W'(32'(page_q) * ROW_BYTES + 32'(slot_off >> 1)
		+ (slot_off[0] ? CHIP_COLUMNS : 0));

	assign pix_page = pixel_y[5:3];
	assign pix_in   = (32'(x_q) < ROW_BYTES) && (32'(y_q[5:3]) < PAGE_COUNT);
	assign pix_addr = ADDR_W'(32'(y_q[5:3]) * ROW_BYTES + 32'(x_q));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = 8'h00;
		if (cmd.clear_wr) begin
			wr_en = 1'b1;
		end else if (cmd.commit && pix_in
				&& (func_q == FUNC_SET || func_q == FUNC_CLEAR)) begin
			wr_en   = 1'b1;
			wr_addr = pix_addr;
			wr_data = (func_q == FUNC_SET) ? (8'h01 << y_q[2:0]) : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.load) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			x_q    <= pixel_x;
			y_q    <= {pix_page, pixel_y[2:0]};
			stat_q <= status_byte;
		end
	end

	assign slot_inc = slot_q + SLOT_W'(1);

	always_comb begin
		r_bus_valid = 1'b0;
		r_poll      = 1'b0;
		r_chip      = 1'b0;
		r_data      = 1'b0;
		r_byte      = 8'h00;
		r_done      = 1'b0;
		refr_nx     = refr_q;
		page_nx     = page_q;
		slot_nx     = slot_q;
		unique case (func_q)
			FUNC_START: begin
				if (!refr_q) begin
					refr_nx = 1'b1;
					page_nx = '0;
					slot_nx = '0;
				end
			end
			FUNC_STEP: begin
				if (refr_q) begin
					r_chip = slot_q[0];
					r_data = (32'(slot_q) >= 4);
					if ((stat_q & BUSY_MASK) != 8'h00) begin
						r_poll = 1'b1;
					end else begin
						r_bus_valid = 1'b1;
						if (32'(slot_q) < 2) begin
							r_byte = CMD_PAGE | (8'(page_q) & 8'h07);
						end else if (32'(slot_q) < 4) begin
							r_byte = CMD_COLUMN0;
						end else begin
							r_byte = rd_data_q;
						end
						slot_nx = slot_inc;
						if (32'(slot_inc) >= SLOTS_PER_PAGE) begin
							slot_nx = '0;
							page_nx = page_q + PAGE_W'(1);
							if (32'(page_q) >= PAGE_COUNT - 1) begin
								page_nx = '0;
								refr_nx = 1'b0;
								r_done  = 1'b1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refr_q      <= 1'b0;
			page_q      <= '0;
			slot_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_wr) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.commit) begin
				refr_q      <= refr_nx;
				page_q      <= page_nx;
				slot_q      <= slot_nx;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			bus_valid_q <= r_bus_valid;
			poll_q      <= r_poll;
			chip_q      <= r_chip;
			data_q      <= r_data;
			byte_q      <= r_byte;
			done_q      <= r_done;
			active_q    <= refr_nx;
		end
	end

	assign status.clear_last  = (clr_q == ADDR_W'(STORE_BYTES - 1));
	assign status.out_blocked = out_valid_q && out_stall;

	assign out_valid      = out_valid_q;
	assign bus_valid      = bus_valid_q;
	assign status_poll    = poll_q;
	assign chip_select    = chip_q;
	assign is_data        = data_q;
	assign bus_byte       = byte_q;
	assign frame_done     = done_q;
	assign refresh_active = active_q;

endmodule

// ===== hw/rtl/lcd_framebuffer_refresh_engine.sv =====
// Top level of the LCD frame-store refresh engine: controller and datapath joined.
//
// This block keeps a 128 by 64 monochrome frame store of 1024 bytes and streams it, one display
// bus step per transaction, to a two-chip page-organised graphic LCD. Each input transaction gives
// exactly one result transaction. After reset the frame store is cleared by a pass that writes one
// byte per cycle, so the block holds in_stall high until the whole store is cleared. From then on
// a transaction is accepted in the idle state, where the frame-store byte for the current refresh
// position is read from the single synchronous read port, and then moves to an execute state in
// which the store is written, the refresh position moves on and the result is loaded into the
// output register. A new transaction is accepted while an earlier result still waits in that
// register; only when the output side keeps the register full does the execute state stretch.
// A set-pixel transaction overwrites the addressed byte with the single pixel bit, and a
// clear-pixel transaction zeroes it. A busy status (bit 7 or bit 4 set) makes a bus step report
// status_poll and keeps the refresh where it was, so the same write is offered again.
module lcd_framebuffer_refresh_engine
	import lfre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [6:0] pixel_x,
	input  logic [5:0] pixel_y,
	input  logic [7:0] status_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       bus_valid,
	output logic       status_poll,
	output logic       chip_select,
	output logic       is_data,
	output logic [7:0] bus_byte,
	output logic       frame_done,
	output logic       refresh_active
);

	lfre_cmd_t    cmd;
	lfre_status_t status;

	// The controller sequences the clearing pass, acceptance and execution.
	lfre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the frame store, the refresh position and the result register.
	lfre_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.func           (func),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.status_byte    (status_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.bus_valid      (bus_valid),
		.status_poll    (status_poll),
		.chip_select    (chip_select),
		.is_data        (is_data),
		.bus_byte       (bus_byte),
		.frame_done     (frame_done),
		.refresh_active (refresh_active)
	);

endmodule

// ===== tb/tb_lcd_framebuffer_refresh_engine.sv =====
// Self-checking testbench for the LCD frame-store refresh engine.
module tb_lcd_framebuffer_refresh_engine;
	import lfre_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The run is cut off here. The slowest correct run is roughly 2000 transactions, the
	// store-clearing pass after reset and one long receiver hold-off.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 450;
	localparam int IDLE_PERCENT = 27;

	// One result transaction, in the order of the output ports.
	typedef struct packed {
		logic       bus_valid;
		logic       status_poll;
		logic       chip_select;
		logic       is_data;
		logic [7:0] bus_byte;
		logic       frame_done;
		logic       refresh_active;
	} bus_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	func_t      func;
	logic [6:0] pixel_x;
	logic [5:0] pixel_y;
	logic [7:0] status_byte;
	logic       out_valid;
	logic       out_stall;
	logic       bus_valid;
	logic       status_poll;
	logic       chip_select;
	logic       is_data;
	logic [7:0] bus_byte;
	logic       frame_done;
	logic       refresh_active;

	lcd_framebuffer_refresh_engine uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.status_byte    (status_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.bus_valid      (bus_valid),
		.status_poll    (status_poll),
		.chip_select    (chip_select),
		.is_data        (is_data),
		.bus_byte       (bus_byte),
		.frame_done     (frame_done),
		.refresh_active (refresh_active)
	);

	// Our own copy of the engine's state, advanced once per accepted input transaction.
	logic [7:0]  frame_shadow [STORE_BYTES] = '{default: 8'h00};
	bit          refresh_running = 1'b0;
	int unsigned page_pos = 0;
	int unsigned slot_pos = 0;

	// Results still owed by the engine, oldest first.
	bus_result_t pending_bus_results [$];

	int mismatches = 0;
	int cycle_count = 0;

	// Random idling on either side; the test tasks switch these off for a clean stretch.
	bit tx_jitter = 1'b1;
	bit rx_jitter = 1'b1;
	// A test asks the receiver for a long hold-off by placing a cycle count here.
	int hold_request = 0;

	initial begin : clock_gen
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Works out the result of one input transaction and moves the shadow state on, exactly
	// as the engine is meant to. Set-pixel overwrites the whole byte with one bit; it does
	// not merge with what was there.
	function automatic bus_result_t next_bus_result(input func_t f, input logic [6:0] x,
			input logic [5:0] y, input logic [7:0] status);
		bus_result_t r;
		int unsigned column;
		int unsigned page;
		int unsigned addr;
		int unsigned pair;
		logic [7:0] wr_byte;
		r = '0;
		column = 32'(x);
		page = 32'(y >> 3);
		case (f)
			FUNC_SET: begin
				if (column < ROW_BYTES && page < PAGE_COUNT)
					frame_shadow[page * ROW_BYTES + column] = 8'h01 << y[2:0];
			end
			FUNC_CLEAR: begin
				if (column < ROW_BYTES && page < PAGE_COUNT)
					frame_shadow[page * ROW_BYTES + column] = 8'h00;
			end
			FUNC_START: begin
				// A second start during a refresh is simply ignored.
				if (!refresh_running) begin
					refresh_running = 1'b1;
					page_pos = 0;
					slot_pos = 0;
				end
			end
			FUNC_STEP: begin
				if (refresh_running) begin
					if (slot_pos < 4) begin
						// Page address to both chips, then column zero to both chips.
						r.chip_select = 1'(slot_pos % 2);
						r.is_data = 1'b0;
						wr_byte = (slot_pos < 2) ? (CMD_PAGE | 8'(page_pos % 8)) : CMD_COLUMN0;
					end else begin
						// Data pairs: left-half byte to chip 0, right-half byte to chip 1.
						pair = (slot_pos - 4) / 2;
						r.chip_select = 1'((slot_pos - 4) % 2);
						r.is_data = 1'b1;
						addr = page_pos * ROW_BYTES + pair + (r.chip_select ? CHIP_COLUMNS : 0);
						wr_byte = (addr < STORE_BYTES) ? frame_shadow[addr] : 8'h00;
					end
					if ((status & BUSY_MASK) != 8'h00) begin
						// Busy chip: nothing written, position held for the retry.
						r.status_poll = 1'b1;
					end else begin
						r.bus_valid = 1'b1;
						r.bus_byte = wr_byte;
						slot_pos++;
						if (slot_pos >= SLOTS_PER_PAGE) begin
							slot_pos = 0;
							page_pos++;
							if (page_pos >= PAGE_COUNT) begin
								page_pos = 0;
								refresh_running = 1'b0;
								r.frame_done = 1'b1;
							end
						end
					end
				end
			end
		endcase
		r.refresh_active = refresh_running;
		return r;
	endfunction

	// A status byte that is either busy (bit 7 or bit 4 set) or clear of both busy bits, with
	// the other bits random.
	function automatic logic [7:0] random_status(input bit busy);
		logic [7:0] s;
		s = 8'($urandom_range(255));
		if (busy)
			return s | ($urandom_range(1) ? 8'h80 : 8'h10);
		return s & ~BUSY_MASK;
	endfunction

	// Offers one input transaction and returns at the clock edge where it is accepted. The
	// stall is looked at on the falling edge, where it is settled for the coming rising edge.
	// Valid is only lowered when an idle gap is actually taken, so a run of back-to-back
	// transactions keeps it high throughout.
	task automatic send_item(input func_t f, input logic [6:0] x, input logic [5:0] y,
			input logic [7:0] status);
		while (tx_jitter && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		pixel_x <= x;
		pixel_y <= y;
		status_byte <= status;
		do
			@(negedge clk);
		while (in_stall !== 1'b0);
		@(posedge clk);
		pending_bus_results.push_back(next_bus_result(f, x, y, status));
	endtask

	task automatic compare_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
		end
	endtask

	// Every result transaction is taken apart and checked against the oldest expectation. As
	// with the input side, the falling edge tells which result the next rising edge accepts.
	initial begin : result_checker
		bus_result_t want;
		bus_result_t got;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
				got = {bus_valid, status_poll, chip_select, is_data, bus_byte, frame_done,
					refresh_active};
				if (pending_bus_results.size() == 0) begin
					mismatches++;
					$error("result transaction arrived with nothing outstanding");
				end else begin
					want = pending_bus_results.pop_front();
					compare_field("bus_valid", 8'(want.bus_valid), 8'(got.bus_valid));
					compare_field("status_poll", 8'(want.status_poll), 8'(got.status_poll));
					compare_field("chip_select", 8'(want.chip_select), 8'(got.chip_select));
					compare_field("is_data", 8'(want.is_data), 8'(got.is_data));
					compare_field("bus_byte", want.bus_byte, got.bus_byte);
					compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
					compare_field("refresh_active", 8'(want.refresh_active),
						8'(got.refresh_active));
				end
			end
		end
	end

	// The receiving side: random stalls while jitter is on, and a long hold-off, counted out
	// here, whenever a test asks for one.
	initial begin : result_receiver
		int hold_left;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
				out_stall <= 1'b1;
				while (hold_left > 0) begin
					@(posedge clk);
					hold_left--;
				end
			end
			out_stall <= rx_jitter && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Before any refresh: bus steps must do nothing at all, busy or not, and pixel writes at
	// the corners of the store must land. Two pixels in one byte check that the second write
	// replaces the first rather than adding to it.
	task automatic test_idle_behaviour();
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h00);
		send_item(FUNC_STEP, 7'd127, 6'd63, 8'hFF);
		send_item(FUNC_SET, 7'd0, 6'd0, 8'h00);
		send_item(FUNC_SET, 7'd127, 6'd63, 8'hFF);
		send_item(FUNC_SET, 7'd127, 6'd62, 8'h00);
		send_item(FUNC_SET, 7'd63, 6'd15, 8'h90);
		send_item(FUNC_SET, 7'd64, 6'd8, 8'h6F);
		send_item(FUNC_CLEAR, 7'd127, 6'd63, 8'h00);
	endtask

	// The opening of a refresh: a repeated start that must be ignored, each busy bit on its
	// own and together, a non-busy status with every other bit set, the four instruction
	// writes, and a pixel write landing just before its byte goes out.
	task automatic test_refresh_opening();
		send_item(FUNC_START, 7'd0, 6'd0, 8'h00);
		send_item(FUNC_START, 7'd127, 6'd63, 8'hFF);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h80);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h10);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h90);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h6F);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h00);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h00);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'hFF);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h01);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h00);
		// The right-half byte of the first pair is rewritten while the refresh runs.
		send_item(FUNC_SET, 7'd64, 6'd7, 8'h00);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h00);
		send_item(FUNC_CLEAR, 7'd1, 6'd0, 8'h00);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h00);
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h00);
	endtask

	// Carries one refresh right through to its last data write, so that every page, both
	// chips and the end-of-frame flag are seen. Pixel writes are mixed in and some chips
	// report busy. A bus step after the end must find the engine idle again.
	task automatic test_full_refresh();
		int pick;
		repeat (40)
			send_item(FUNC_SET, 7'($urandom_range(127)), 6'($urandom_range(63)),
				random_status(1'($urandom_range(1))));
		send_item(FUNC_START, 7'd0, 6'd0, 8'h00);
		while (refresh_running) begin
			pick = $urandom_range(99);
			if (pick < 6)
				send_item(FUNC_SET, 7'($urandom_range(127)), 6'($urandom_range(63)),
					random_status(1'b0));
			else if (pick < 10)
				send_item(FUNC_CLEAR, 7'($urandom_range(127)), 6'($urandom_range(63)),
					random_status(1'b1));
			else
				send_item(FUNC_STEP, 7'($urandom_range(127)), 6'($urandom_range(63)),
					random_status($urandom_range(99) < 15));
		end
		send_item(FUNC_STEP, 7'd0, 6'd0, 8'h00);
	endtask

	// Mixed random traffic. Only transactions that do something count towards the total, and
	// the second half runs with no idling on either side.
	task automatic test_random_traffic();
		int counted;
		int pick;
		func_t f;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 55)
				f = FUNC_STEP;
			else if (pick < 70)
				f = FUNC_SET;
			else if (pick < 82)
				f = FUNC_CLEAR;
			else
				f = FUNC_START;
			if (!(f == FUNC_START && refresh_running) && !(f == FUNC_STEP && !refresh_running))
				counted++;
			send_item(f, 7'($urandom_range(127)), 6'($urandom_range(63)),
				random_status($urandom_range(99) < 40));
			if (counted == RANDOM_ITEMS / 2) begin
				tx_jitter = 1'b0;
				rx_jitter = 1'b0;
			end
		end
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
	endtask

	// The receiver stops taking results for a long while and the sender keeps offering
	// transactions back to back, so the result register fills and the engine must stall its
	// input without dropping or reordering anything.
	task automatic test_backpressure();
		hold_request = 300;
		tx_jitter = 1'b0;
		send_item(FUNC_START, 7'd0, 6'd0, 8'h00);
		repeat (40)
			send_item(FUNC_STEP, 7'($urandom_range(127)), 6'($urandom_range(63)),
				random_status($urandom_range(99) < 20));
		tx_jitter = 1'b1;
	endtask

	initial begin : test_sequence
		// All inputs known from time zero; reset held low at the start, then released once.
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_SET;
		pixel_x = '0;
		pixel_y = '0;
		status_byte = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// The engine clears its store after reset; send_item simply waits out the stall.
		test_idle_behaviour();
		test_refresh_opening();
		test_full_refresh();
		test_random_traffic();
		test_backpressure();

		in_valid <= 1'b0;
		while (pending_bus_results.size() != 0)
			@(posedge clk);
		// Wait on to catch any stray result after the last expected one.
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
